// File: src/fmd_pkg.sv
// ----------------------------------------------------------------------------
// fmd_pkg
// Shared types, constants and step codes for the FM phase discriminator.
// ----------------------------------------------------------------------------
package fmd_pkg;

  localparam int SAMPLE_W        = 16;
  localparam int ANGLE_FRAC_W    = 13;
  localparam int GAIN_W          = 16;
  localparam int GAIN_FRAC_W     = 12;
  localparam int MSG_W           = 16;
  localparam int MSG_FRAC_W      = 11;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd326;

  // constants in Q30
  localparam longint K30_CUBIC        = 64'sd210775520;
  localparam longint K30_LINEAR       = 64'sd1054092349;
  localparam longint K30_QTR_PI       = 64'sd843314857;
  localparam longint K30_THREE_QTR_PI = 64'sd2529944570;

  // datapath step codes
  localparam logic [3:0] OP_NONE = 4'd0;
  localparam logic [3:0] OP_LOAD = 4'd1;
  localparam logic [3:0] OP_X0   = 4'd2;
  localparam logic [3:0] OP_X1   = 4'd3;
  localparam logic [3:0] OP_Y0   = 4'd4;
  localparam logic [3:0] OP_Y1   = 4'd5;
  localparam logic [3:0] OP_PREP = 4'd6;
  localparam logic [3:0] OP_DIV  = 4'd7;
  localparam logic [3:0] OP_R2   = 4'd8;
  localparam logic [3:0] OP_U    = 4'd9;
  localparam logic [3:0] OP_ANG  = 4'd10;
  localparam logic [3:0] OP_MSG  = 4'd11;

  typedef struct packed {
    logic [3:0] op;
    logic       div_first;
  } fmd_cmd_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_i;
    logic signed [SAMPLE_W-1:0] sample_q;
    logic                       block_end;
  } fmd_in_t;

  typedef struct packed {
    logic signed [MSG_W-1:0] message;
    logic                    block_end_out;
  } fmd_out_t;

  // Q30 constant rounded half up to f fraction bits (all constants positive)
  function automatic longint from_q30(longint k, int f);
    longint t;
    t = k + (longint'(1) <<< (29 - f));
    return t >>> (30 - f);
  endfunction

endpackage

// File: src/fmd_ctrl.sv
// ----------------------------------------------------------------------------
// fmd_ctrl
// Sequencer: walks one word through multiply, divide and polynomial steps.
// ----------------------------------------------------------------------------
module fmd_ctrl import fmd_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_W
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output fmd_cmd_t cmd
);

  localparam int CW = $clog2(ANGLE_FRAC_BITS + 1);
  localparam logic [CW-1:0] DIV_LAST = CW'(ANGLE_FRAC_BITS);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_X0   = 4'd1;
  localparam logic [3:0] ST_X1   = 4'd2;
  localparam logic [3:0] ST_Y0   = 4'd3;
  localparam logic [3:0] ST_Y1   = 4'd4;
  localparam logic [3:0] ST_PREP = 4'd5;
  localparam logic [3:0] ST_DIV  = 4'd6;
  localparam logic [3:0] ST_R2   = 4'd7;
  localparam logic [3:0] ST_U    = 4'd8;
  localparam logic [3:0] ST_ANG  = 4'd9;
  localparam logic [3:0] ST_MSG  = 4'd10;

  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          slot_free;

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd.op        = OP_NONE;
    cmd.div_first = (cnt_r == '0);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = ST_X0;
        end
      end
      ST_X0:   begin cmd.op = OP_X0;   state_nxt = ST_X1; end
      ST_X1:   begin cmd.op = OP_X1;   state_nxt = ST_Y0; end
      ST_Y0:   begin cmd.op = OP_Y0;   state_nxt = ST_Y1; end
      ST_Y1:   begin cmd.op = OP_Y1;   state_nxt = ST_PREP; end
      ST_PREP: begin
        cmd.op    = OP_PREP;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.op  = OP_DIV;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) state_nxt = ST_R2;
      end
      ST_R2:   begin cmd.op = OP_R2;   state_nxt = ST_U; end
      ST_U:    begin cmd.op = OP_U;    state_nxt = ST_ANG; end
      ST_ANG:  begin cmd.op = OP_ANG;  state_nxt = ST_MSG; end
      ST_MSG: begin
        if (slot_free) begin
          cmd.op        = OP_MSG;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: src/fmd_datapath.sv
// ----------------------------------------------------------------------------
// fmd_datapath
// Shared multiplier, restoring divider and the atan2 polynomial registers.
// ----------------------------------------------------------------------------
module fmd_datapath import fmd_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  fmd_cmd_t          cmd,
  input  fmd_in_t           in_data,
  input  logic              cfg_wr_en,
  input  logic [GAIN_W-1:0] cfg_wr_data,
  output fmd_out_t          out_data
);

  localparam int SW  = SAMPLE_W;
  localparam int F   = ANGLE_FRAC_BITS;
  localparam int XW  = 2 * SW + 1;
  localparam int DW  = 2 * SW + 2;
  localparam int RW  = F + 2;
  localparam int AW  = F + 3;
  localparam int M1  = (SW + 1 > AW) ? SW + 1 : AW;
  localparam int MW  = (M1 > GAIN_W + 1) ? M1 : GAIN_W + 1;
  localparam int PW  = 2 * MW;
  localparam int SH  = F + GAIN_FRAC_W - MSG_FRAC_W;

  localparam logic signed [AW-1:0] K_CUBIC  = AW'(from_q30(K30_CUBIC, F));
  localparam logic signed [AW-1:0] K_LINEAR = AW'(from_q30(K30_LINEAR, F));
  localparam logic signed [AW-1:0] K_B1     = AW'(from_q30(K30_QTR_PI, F));
  localparam logic signed [AW-1:0] K_B3     = AW'(from_q30(K30_THREE_QTR_PI, F));
  localparam logic signed [PW:0]   MSG_MAXV = (PW+1)'(32767);
  localparam logic signed [PW:0]   MSG_MINV = -(PW+1)'(32768);

  logic signed [SW-1:0] prev_i_r, prev_q_r, cur_i_r, cur_q_r;
  logic                 blk_r;
  logic [GAIN_W-1:0]    gain_r;
  logic signed [XW-1:0] x_r, y_r;
  logic [DW:0]          rem_r;
  logic [DW-1:0]        den_r;
  logic [F:0]           q_r;
  logic                 neg_r, yneg_r;
  logic signed [AW-1:0] base_r, u_r, ang_r;
  logic signed [RW-1:0] r_r, r2_r;
  fmd_out_t             out_r;

  logic signed [MW-1:0] ma, mb;
  logic signed [PW-1:0] prod;
  logic signed [DW-1:0] xe, ye, abs_y, a_v, num_v, den_v;
  logic [DW:0]          t_v;
  logic signed [RW-1:0] r_c;
  logic signed [PW:0]   rnd_v, msg_v;

  assign r_c = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      OP_X0:   begin ma = MW'(prev_i_r); mb = MW'(cur_i_r); end
      OP_X1:   begin ma = MW'(prev_q_r); mb = MW'(cur_q_r); end
      OP_Y0:   begin ma = MW'(prev_i_r); mb = MW'(cur_q_r); end
      OP_Y1:   begin ma = MW'(prev_q_r); mb = MW'(cur_i_r); end
      OP_R2:   begin ma = MW'(r_c);      mb = MW'(r_c);     end
      OP_U:    begin ma = MW'(K_CUBIC);  mb = MW'(r2_r);    end
      OP_ANG:  begin ma = MW'(u_r);      mb = MW'(r_r);     end
      OP_MSG:  begin ma = MW'(ang_r);    mb = $signed(MW'({1'b0, gain_r})); end
      default: begin ma = '0;            mb = '0;           end
    endcase
  end

  assign prod = ma * mb;

  // angle prep: a = |y| + 1, then num / den by sign of x
  always_comb begin
    xe    = DW'(x_r);
    ye    = DW'(y_r);
    abs_y = ye[DW-1] ? -ye : ye;
    a_v   = abs_y + DW'(1);
    if (xe[DW-1]) begin
      num_v = xe + a_v;
      den_v = a_v - xe;
    end else begin
      num_v = xe - a_v;
      den_v = xe + a_v;
    end
  end

  assign t_v   = cmd.div_first ? rem_r : {rem_r[DW-1:0], 1'b0};
  assign rnd_v = (PW+1)'(prod) + ((PW+1)'(1) <<< (SH - 1));
  assign msg_v = rnd_v >>> SH;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_i_r <= '0;
      prev_q_r <= '0;
      gain_r   <= GAIN_RESET;
    end else if (cfg_wr_en) begin
      gain_r   <= cfg_wr_data;
      prev_i_r <= '0;
      prev_q_r <= '0;
    end else if (cmd.op == OP_PREP) begin
      prev_i_r <= cur_i_r;
      prev_q_r <= cur_q_r;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        cur_i_r <= SW'(in_data.sample_i);
        cur_q_r <= SW'(in_data.sample_q);
        blk_r   <= in_data.block_end;
      end
      OP_X0: x_r <= XW'(prod);
      OP_X1: x_r <= x_r + XW'(prod);
      OP_Y0: y_r <= XW'(prod);
      OP_Y1: y_r <= y_r - XW'(prod);
      OP_PREP: begin
        neg_r  <= num_v[DW-1];
        rem_r  <= {1'b0, num_v[DW-1] ? -num_v : num_v};
        den_r  <= den_v;
        base_r <= xe[DW-1] ? K_B3 : K_B1;
        yneg_r <= y_r[XW-1];
        q_r    <= '0;
      end
      OP_DIV: begin
        if (t_v >= {1'b0, den_r}) begin
          rem_r <= t_v - {1'b0, den_r};
          q_r   <= {q_r[F-1:0], 1'b1};
        end else begin
          rem_r <= t_v;
          q_r   <= {q_r[F-1:0], 1'b0};
        end
      end
      OP_R2: begin
        r_r  <= r_c;
        r2_r <= RW'(prod >>> F);
      end
      OP_U:  u_r <= AW'(prod >>> F) - K_LINEAR;
      OP_ANG: begin
        if (yneg_r) ang_r <= -(base_r + AW'((prod + (PW'(1) <<< (F - 1))) >>> F));
        else        ang_r <=   base_r + AW'((prod + (PW'(1) <<< (F - 1))) >>> F);
      end
      OP_MSG: begin
        if (msg_v > MSG_MAXV)      out_r.message <= MSG_W'(MSG_MAXV);
        else if (msg_v < MSG_MINV) out_r.message <= MSG_W'(MSG_MINV);
        else                       out_r.message <= MSG_W'(msg_v);
        out_r.block_end_out <= blk_r;
      end
      default: ;
    endcase
  end

  assign out_data = out_r;

endmodule

// File: src/fm_differential_phase_discriminator.sv
// ----------------------------------------------------------------------------
// fm_differential_phase_discriminator
// Conjugate-product FM discriminator with rational atan2 and gain scaling.
// ----------------------------------------------------------------------------
//  channel | signals                          | word
//  in      | in_valid, in_stall, in_data      | sample_i, sample_q, block_end
//  out     | out_valid, out_stall, out_data   | message, block_end_out
//  cfg     | cfg_wr_en, cfg_wr_data           | output_gain
//
//  A word is loaded, then passes the shared multiplier (eight products) and
//  the bit-per-cycle restoring divider before its result is registered; the
//  input reopens in the same cycle as the result becomes valid, so a word is
//  taken only once the previous word has left the sequencer.
//  Reset is synchronous; gain returns to 326 and the stored sample clears.
//  A new word is taken while a result waits; a stalled result holds the
//  sequencer in its last step until the output register frees.
module fm_differential_phase_discriminator import fmd_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  fmd_in_t           in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output fmd_out_t          out_data,
  input  logic              cfg_wr_en,
  input  logic [GAIN_W-1:0] cfg_wr_data
);

  fmd_cmd_t cmd;

  fmd_ctrl #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  fmd_datapath #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_data    (out_data)
  );

endmodule
